### design/sg_list_range_extract_macros.svh
`ifndef SG_LIST_RANGE_EXTRACT_MACROS_SVH
`define SG_LIST_RANGE_EXTRACT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define SGRE_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define SGRE_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

### design/sgre_pkg.sv
package sgre_pkg;

  localparam int unsigned BaseW = 64;
  localparam int unsigned LenW  = 32;
  localparam int unsigned CfgW  = 64;
  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = BaseW + LenW;

  localparam logic REG_OFFSET = 1'b0;
  localparam logic REG_LENGTH = 1'b1;

  localparam logic [1:0] PH_SEEK = 2'd0;
  localparam logic [1:0] PH_IN   = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;

endpackage

### design/sg_list_range_extract.sv
// Scatter-gather range trimmer: takes one segment descriptor per cycle and
// returns the descriptors that cover [range_offset, range_offset+range_length)
// of the current list, the final one with out_tlast set; a list that ends
// before the range is covered yields one request with out_tuser set and zero
// data. Each request passes through combinational logic (64-bit compares, a
// subtract and an add) between the input and the output register, so a new
// descriptor is taken every cycle and its result shows in the next cycle; in_tready
// drops only while a result sits in the output register and out_tready is low.
// Write the range registers only while no list is in flight.
module sg_list_range_extract
  import sgre_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [DataW-1:0] in_tdata,   // seg_base[63:0], seg_len[95:64]
  input  logic             in_tlast,   // list_end
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [DataW-1:0] out_tdata,  // out_base[63:0], out_len[95:64]
  output logic             out_tlast,  // is_last
  output logic             out_tuser,  // range_error
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [AddrW-1:0] cfg_paddr,
  input  logic [CfgW-1:0]  cfg_pwdata,
  output logic [CfgW-1:0]  cfg_prdata,
  output logic             cfg_pready
);

  logic [CfgW-1:0]  off_r, off_nxt, rng_len_r, rng_len_nxt;
  logic [CfgW-1:0]  pos_r, pos_nxt, gap_r, gap_nxt, rem_r, rem_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [BaseW-1:0] out_base_r, out_base_nxt;
  logic [LenW-1:0]  out_len_r, out_len_nxt;
  logic             out_last_r, out_last_nxt, out_err_r, out_err_nxt;

  logic [BaseW-1:0] seg_base;
  logic [LenW-1:0]  seg_len, avail;
  logic             list_end, in_acc, cfg_wr;
  logic             seek_open, fits, in_cover, emit;
  logic [BaseW-1:0] e_base;
  logic [LenW-1:0]  e_len;
  logic             e_last, e_err;

  assign seg_base = in_tdata[BaseW-1:0];
  assign seg_len  = in_tdata[DataW-1:BaseW];
  assign list_end = in_tlast;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_wr    = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  assign seek_open = {{(CfgW-LenW){1'b0}}, seg_len} > gap_r;
  assign avail     = seg_len - gap_r[LenW-1:0];
  assign fits      = rng_len_r <= {{(CfgW-LenW){1'b0}}, avail};
  assign in_cover  = {{(CfgW-LenW){1'b0}}, seg_len} >= rem_r;

  always_comb begin
    pos_nxt   = pos_r;
    gap_nxt   = gap_r;
    rem_nxt   = rem_r;
    phase_nxt = phase_r;
    off_nxt   = off_r;
    rng_len_nxt = rng_len_r;
    emit   = 1'b0;
    e_base = '0;
    e_len  = '0;
    e_last = 1'b0;
    e_err  = 1'b0;
    if (in_acc) begin
      case (phase_r)
        PH_SEEK: begin
          if (seek_open) begin
            emit   = 1'b1;
            e_base = seg_base + gap_r;
            if (fits) begin
              e_len     = rng_len_r[LenW-1:0];
              e_last    = 1'b1;
              phase_nxt = PH_DONE;
            end else if (list_end) begin
              e_base = '0;
              e_err  = 1'b1;
            end else begin
              e_len     = avail;
              rem_nxt   = rng_len_r - {{(CfgW-LenW){1'b0}}, avail};
              phase_nxt = PH_IN;
            end
          end else begin
            pos_nxt = pos_r + {{(CfgW-LenW){1'b0}}, seg_len};
            gap_nxt = gap_r - {{(CfgW-LenW){1'b0}}, seg_len};
            if (list_end) begin
              emit  = 1'b1;
              e_err = 1'b1;
            end
          end
        end
        PH_IN: begin
          emit = 1'b1;
          if (in_cover) begin
            e_base    = seg_base;
            e_len     = rem_r[LenW-1:0];
            e_last    = 1'b1;
            rem_nxt   = '0;
            phase_nxt = PH_DONE;
          end else if (list_end) begin
            e_err = 1'b1;
          end else begin
            e_base  = seg_base;
            e_len   = seg_len;
            rem_nxt = rem_r - {{(CfgW-LenW){1'b0}}, seg_len};
          end
        end
        default: begin
        end
      endcase
      if (list_end) begin
        pos_nxt   = '0;
        gap_nxt   = off_r;
        rem_nxt   = '0;
        phase_nxt = PH_SEEK;
      end
    end
    if (cfg_wr) begin
      if (cfg_paddr[AddrW-1] == REG_OFFSET) begin
        off_nxt = cfg_pwdata;
        gap_nxt = cfg_pwdata - pos_r;
      end else begin
        rng_len_nxt = cfg_pwdata;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_base_nxt  = out_base_r;
    out_len_nxt   = out_len_r;
    out_last_nxt  = out_last_r;
    out_err_nxt   = out_err_r;
    if (in_acc) begin
      out_valid_nxt = emit;
      if (emit) begin
        out_base_nxt = e_base;
        out_len_nxt  = e_len;
        out_last_nxt = e_last;
        out_err_nxt  = e_err;
      end
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r       <= '0;
      rng_len_r   <= '0;
      pos_r       <= '0;
      gap_r       <= '0;
      rem_r       <= '0;
      phase_r     <= PH_SEEK;
      out_valid_r <= 1'b0;
    end else begin
      off_r       <= off_nxt;
      rng_len_r   <= rng_len_nxt;
      pos_r       <= pos_nxt;
      gap_r       <= gap_nxt;
      rem_r       <= rem_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_base_r <= out_base_nxt;
    out_len_r  <= out_len_nxt;
    out_last_r <= out_last_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_len_r, out_base_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_err_r;

  assign cfg_prdata = (cfg_paddr[AddrW-1] == REG_LENGTH) ? rng_len_r : off_r;
  assign cfg_pready = 1'b1;

endmodule

### design/sgre_checker.sv
`include "sg_list_range_extract_macros.svh"

module sgre_checker
  import sgre_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [DataW-1:0] out_tdata,  // out_base[63:0], out_len[95:64]
  input logic             out_tlast,  // is_last
  input logic             out_tuser   // range_error
);

  `SGRE_ASSERT_NOW(a_err_zero, clk, rst_n, out_tvalid && out_tuser, out_tdata == '0 && !out_tlast, "error request carries data")

  `SGRE_ASSERT_NOW(a_last_no_err, clk, rst_n, out_tvalid && out_tlast, !out_tuser, "last request flagged as error")

  `SGRE_ASSERT_NOW(a_ready_free, clk, rst_n, !out_tvalid || out_tready, in_tready, "input stalled with free output")

  `SGRE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser), "stalled result changed")

endmodule

bind sg_list_range_extract sgre_checker u_sgre_checker (.*);

### verif/sg_list_range_extract_tb.sv
module sg_list_range_extract_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sgre_pkg::*;

  localparam int unsigned MaxCycles    = 400000;
  localparam int unsigned RandomItems  = 700;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned PhaseItems   = 50;

  typedef struct packed {
    logic [BaseW-1:0] base;
    logic [LenW-1:0]  len;
    logic             last;
    logic             err;
  } sg_desc_t;

  class sg_trim_board;
    logic [CfgW-1:0] range_off;
    logic [CfgW-1:0] range_len;
    logic [CfgW-1:0] seek_pos;
    logic [CfgW-1:0] left_bytes;
    logic [1:0]      state;
    sg_desc_t        due_q[$];
    int unsigned     mismatches;

    function void clear_list();
      seek_pos   = '0;
      left_bytes = '0;
      state      = PH_SEEK;
    endfunction

    function void reset_all();
      range_off  = '0;
      range_len  = '0;
      mismatches = 0;
      clear_list();
    endfunction

    function void write_reg(logic idx, logic [CfgW-1:0] value);
      if (idx == REG_OFFSET) begin
        range_off = value;
      end else begin
        range_len = value;
      end
    endfunction

    function void push_desc(logic [BaseW-1:0] base, logic [LenW-1:0] len, logic last,
                            logic err);
      sg_desc_t d;
      d.base = base;
      d.len  = len;
      d.last = last;
      d.err  = err;
      due_q.push_back(d);
    endfunction

    function void note_request(logic [BaseW-1:0] base, logic [LenW-1:0] len,
                               logic list_end);
      logic [CfgW-1:0] len_w;
      logic [CfgW-1:0] gap;
      logic [CfgW-1:0] avail;
      len_w = len;
      if (state == PH_SEEK) begin
        gap = range_off - seek_pos;
        if (len_w > gap) begin
          avail = len_w - gap;
          if (range_len <= avail) begin
            push_desc(base + gap, range_len[LenW-1:0], 1'b1, 1'b0);
            state = PH_DONE;
          end else if (list_end) begin
            push_desc('0, '0, 1'b0, 1'b1);
          end else begin
            push_desc(base + gap, avail[LenW-1:0], 1'b0, 1'b0);
            left_bytes = range_len - avail;
            state      = PH_IN;
          end
        end else begin
          seek_pos = seek_pos + len_w;
          if (list_end) begin
            push_desc('0, '0, 1'b0, 1'b1);
          end
        end
      end else if (state == PH_IN) begin
        if (len_w >= left_bytes) begin
          push_desc(base, left_bytes[LenW-1:0], 1'b1, 1'b0);
          left_bytes = '0;
          state      = PH_DONE;
        end else if (list_end) begin
          push_desc('0, '0, 1'b0, 1'b1);
        end else begin
          push_desc(base, len, 1'b0, 1'b0);
          left_bytes = left_bytes - len_w;
        end
      end
      if (list_end) begin
        clear_list();
      end
    endfunction

    function void check_result(logic [BaseW-1:0] base, logic [LenW-1:0] len, logic last,
                               logic err);
      sg_desc_t want;
      if (due_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected request base %h len %h last %b err %b", $time, base, len,
                 last, err);
        return;
      end
      want = due_q.pop_front();
      if (base !== want.base) begin
        mismatches++;
        $display("%0t: out_base expected %h actual %h", $time, want.base, base);
      end
      if (len !== want.len) begin
        mismatches++;
        $display("%0t: out_len expected %h actual %h", $time, want.len, len);
      end
      if (last !== want.last) begin
        mismatches++;
        $display("%0t: is_last expected %b actual %b", $time, want.last, last);
      end
      if (err !== want.err) begin
        mismatches++;
        $display("%0t: range_error expected %b actual %b", $time, want.err, err);
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [DataW-1:0] in_tdata;   // seg_base[63:0], seg_len[95:64]
  logic             in_tlast;   // list_end
  logic             out_tvalid;
  logic             out_tready;
  logic [DataW-1:0] out_tdata;  // out_base[63:0], out_len[95:64]
  logic             out_tlast;  // is_last
  logic             out_tuser;  // range_error
  logic             cfg_psel;
  logic             cfg_penable;
  logic             cfg_pwrite;
  logic [AddrW-1:0] cfg_paddr;
  logic [CfgW-1:0]  cfg_pwdata;
  logic [CfgW-1:0]  cfg_prdata;
  logic             cfg_pready;

  sg_trim_board sb;
  int unsigned  sent;
  int unsigned  cycles;
  bit           in_burst;
  bit           out_burst;

  sg_list_range_extract dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial clk = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > MaxCycles) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata[BaseW-1:0], out_tdata[DataW-1:BaseW], out_tlast, out_tuser);
    end
  end

  initial begin
    int unsigned stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = out_burst ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  task automatic send_seg(input logic [BaseW-1:0] base, input logic [LenW-1:0] len,
                          input logic list_end);
    int unsigned gap;
    gap = in_burst ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  = {len, base};
    in_tlast  = list_end;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_request(base, len, list_end);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid = 1'b0;
    while (sb.due_q.size() != 0) @(posedge clk);
    @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [CfgW-1:0] value);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {idx, 3'b000};
    cfg_pwdata  = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.write_reg(idx, value);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    if (cfg_prdata !== value) begin
      sb.mismatches++;
      $display("%0t: register read expected %h actual %h", $time, value, cfg_prdata);
    end
  endtask

  task automatic set_range(input logic [CfgW-1:0] off, input logic [CfgW-1:0] len);
    drain();
    cfg_write(REG_OFFSET, off);
    cfg_write(REG_LENGTH, len);
  endtask

  task automatic run_list(input int unsigned nseg, input bit wide);
    logic [LenW-1:0] len;
    int unsigned     pick;
    for (int unsigned i = 0; i < nseg; i++) begin
      pick = $urandom_range(0, 9);
      if (wide || pick == 0) begin
        len = $urandom;
      end else if (pick < 3) begin
        len = '0;
      end else begin
        len = $urandom_range(1, 48);
      end
      send_seg({$urandom, $urandom}, len, i == nseg - 1);
    end
  endtask

  initial begin
    logic [CfgW-1:0] off;
    logic [CfgW-1:0] len;
    int unsigned     phase_no;
    int unsigned     start;
    int unsigned     target;
    bit              wide;

    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    sent        = 0;
    cycles      = 0;
    in_burst    = 1'b0;
    out_burst   = 1'b0;
    sb = new();
    sb.reset_all();
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // zero-length range, zero-length segments never open it
    set_range(0, 0);
    send_seg({$urandom, $urandom}, 0, 1'b0);
    send_seg('1, 5, 1'b0);
    send_seg({$urandom, $urandom}, 3, 1'b1);
    send_seg({$urandom, $urandom}, 0, 1'b1);

    // trimmed front and end, empty middle segment, tail ignored
    set_range(10, 20);
    send_seg({$urandom, $urandom}, 4, 1'b0);
    send_seg({$urandom, $urandom}, 0, 1'b0);
    send_seg({$urandom, $urandom}, 8, 1'b0);
    send_seg({$urandom, $urandom}, 0, 1'b0);
    send_seg({$urandom, $urandom}, 30, 1'b0);
    send_seg({$urandom, $urandom}, 7, 1'b0);
    send_seg({$urandom, $urandom}, 3, 1'b1);

    // list too short
    set_range(0, 100);
    send_seg({$urandom, $urandom}, 10, 1'b0);
    send_seg({$urandom, $urandom}, 10, 1'b1);

    // offset at list end
    set_range(20, 1);
    send_seg({$urandom, $urandom}, 10, 1'b0);
    send_seg({$urandom, $urandom}, 10, 1'b1);

    // address wrap
    set_range(5, 4);
    send_seg(64'hFFFF_FFFF_FFFF_FFFD, 10, 1'b1);

    set_range('1, '1);
    send_seg('1, '1, 1'b1);

    set_range(0, 64'h0000_0000_FFFF_FFFF);
    send_seg('0, '1, 1'b1);

    target   = sent + RandomItems;
    phase_no = 0;
    while (sent < target) begin
      in_burst  = (phase_no % 4 == 3);
      out_burst = (phase_no % 5 == 2);
      wide      = 1'b0;
      case (phase_no % 6)
        0: begin
          off = $urandom_range(0, 100);
          len = $urandom_range(0, 150);
        end
        1: begin
          off = 0;
          len = $urandom_range(0, 200);
        end
        2: begin
          off = $urandom_range(0, 150);
          len = 0;
        end
        3: begin
          off  = $urandom;
          len  = $urandom;
          wide = 1'b1;
        end
        4: begin
          off  = '1;
          len  = '1;
          wide = $urandom_range(0, 1);
        end
        default: begin
          off  = {$urandom, $urandom};
          len  = {$urandom, $urandom};
          wide = 1'b1;
        end
      endcase
      set_range(off, len);
      start = sent;
      while (sent - start < PhaseItems) run_list($urandom_range(1, 8), wide);
      phase_no++;
    end

    drain();
    if (sb.mismatches == 0 && sb.due_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
